[rtl/hld_pkg.sv]
// Package for the HSV to LED pulse-width pipeline: shared constants, the hue
// sector type, the stage advance struct and the divide-by-full-scale function.
// Depends on nothing.
package hld_pkg;

	localparam int NUM_STAGES = 10;

	localparam logic [15:0] FULL_SCALE       = 16'hFFFF;
	localparam logic [15:0] HUE_WRAP         = 16'd36000;
	localparam logic [15:0] SECTOR_CDEG      = 16'd6000;
	localparam logic [15:0] HUE_RAMP_SPAN    = 16'd12000;
	localparam logic [10:0] RAMP_ONE         = 11'd1000;
	localparam logic [15:0] PWM_PERIOD_RESET = 16'd1000;

	// Reciprocal constants: x / 6 for x below 2^17, and x / 125 for x below 2^24.
	localparam logic [15:0] DIV6_MUL     = 16'd43691;
	localparam int          DIV6_SHIFT   = 18;
	localparam logic [23:0] DIV125_MUL   = 24'd8589935;
	localparam int          DIV125_SHIFT = 30;

	typedef enum logic [2:0] {
		SECTOR_R_G = 3'd0,
		SECTOR_G_R = 3'd1,
		SECTOR_G_B = 3'd2,
		SECTOR_B_G = 3'd3,
		SECTOR_B_R = 3'd4,
		SECTOR_R_B = 3'd5
	} hld_sector_t;

	// Load enables of the four stages inside one channel scaler.
	typedef struct packed {
		logic s7;
		logic s8;
		logic s9;
		logic s10;
	} hld_adv_t;

	// Truncating division by 65535 of a product of two 16-bit values.
	// The remainder estimate stays below twice the divisor, so one
	// correction is enough.
	function automatic logic [15:0] div_full_scale(input logic [31:0] p);
		logic [16:0] rem;
		rem = {1'b0, p[15:0]} + {1'b0, p[31:16]};
		return p[31:16] + {15'd0, (rem >= {1'b0, FULL_SCALE})};
	endfunction

endpackage

[rtl/hsv_led_pwm_drive.sv]
// HSV to common-anode LED pulse widths. One transaction is accepted per cycle
// while a stalled output does not hold the input back, set by the ten-stage
// pipeline that carries each accepted input transaction to a valid result.
// A stalled output fills empty stages before holding the input back.
// Reset clears all stage valid bits and sets the PWM period to 1000 us.
module hsv_led_pwm_drive (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic [15:0] cfg_wr_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [15:0] hue_cdeg,
	input  logic [15:0] saturation,
	input  logic [15:0] value_level,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [15:0] red_pulse_us,
	output logic [15:0] green_pulse_us,
	output logic [15:0] blue_pulse_us
);

	localparam int N = hld_pkg::NUM_STAGES;

	logic [15:0]  period_q;
	logic [N:1]   stage_valid_q;
	logic [N:1]   stage_en;
	hld_pkg::hld_adv_t adv;

	logic [31:0]          vs_prod_s1;
	logic [15:0]          val_s1;
	logic [13:0]          hue_rem_s1;
	hld_pkg::hld_sector_t sector_s1;

	logic [15:0]          chroma_s2;
	logic [15:0]          val_s2;
	logic [10:0]          pos_s2;
	hld_pkg::hld_sector_t sector_s2;

	logic [15:0]          chroma_s3;
	logic [15:0]          offs_s3;
	logic [9:0]           weight_s3;
	hld_pkg::hld_sector_t sector_s3;

	logic [15:0]          chroma_s4;
	logic [15:0]          offs_s4;
	logic [25:0]          sec_prod_s4;
	hld_pkg::hld_sector_t sector_s4;

	logic [15:0]          chroma_s5;
	logic [15:0]          offs_s5;
	logic [15:0]          sec_s5;
	hld_pkg::hld_sector_t sector_s5;

	logic [15:0] red_s6;
	logic [15:0] green_s6;
	logic [15:0] blue_s6;

	logic [15:0]          hue_wrapped;
	logic [15:0]          ramp_base;
	logic [15:0]          hue_rem_full;
	hld_pkg::hld_sector_t sector_d;
	logic [29:0]          div6_prod;
	logic [10:0]          ramp_dist;
	logic [10:0]          weight_full;
	logic [46:0]          div125_prod;
	logic [15:0]          red_d;
	logic [15:0]          green_d;
	logic [15:0]          blue_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			period_q <= hld_pkg::PWM_PERIOD_RESET;
		end else if (cfg_wr_en) begin
			period_q <= cfg_wr_data;
		end
	end

	// A stage may load when it is empty or when the stage after it loads.
	always_comb begin
		stage_en[N] = !stage_valid_q[N] || out_ready;
		for (int k = N - 1; k >= 1; k--) begin
			stage_en[k] = !stage_valid_q[k] || stage_en[k + 1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stage_valid_q <= '0;
		end else begin
			if (stage_en[1]) begin
				stage_valid_q[1] <= in_valid;
			end
			for (int k = 2; k <= N; k++) begin
				if (stage_en[k]) begin
					stage_valid_q[k] <= stage_valid_q[k - 1];
				end
			end
		end
	end

	assign in_ready  = stage_en[1];
	assign out_valid = stage_valid_q[N];

	// Stage 1: hue reduction into sector and ramp position.
	always_comb begin
		hue_wrapped = (hue_cdeg >= hld_pkg::HUE_WRAP) ? hue_cdeg - hld_pkg::HUE_WRAP : hue_cdeg;
		priority if (hue_wrapped >= 16'(5 * hld_pkg::SECTOR_CDEG)) begin
			sector_d = hld_pkg::SECTOR_R_B;
		end else if (hue_wrapped >= 16'(4 * hld_pkg::SECTOR_CDEG)) begin
			sector_d = hld_pkg::SECTOR_B_R;
		end else if (hue_wrapped >= 16'(3 * hld_pkg::SECTOR_CDEG)) begin
			sector_d = hld_pkg::SECTOR_B_G;
		end else if (hue_wrapped >= 16'(2 * hld_pkg::SECTOR_CDEG)) begin
			sector_d = hld_pkg::SECTOR_G_B;
		end else if (hue_wrapped >= hld_pkg::SECTOR_CDEG) begin
			sector_d = hld_pkg::SECTOR_G_R;
		end else begin
			sector_d = hld_pkg::SECTOR_R_G;
		end
		priority if (hue_cdeg >= 16'(5 * hld_pkg::HUE_RAMP_SPAN)) begin
			ramp_base = 16'(5 * hld_pkg::HUE_RAMP_SPAN);
		end else if (hue_cdeg >= 16'(4 * hld_pkg::HUE_RAMP_SPAN)) begin
			ramp_base = 16'(4 * hld_pkg::HUE_RAMP_SPAN);
		end else if (hue_cdeg >= 16'(3 * hld_pkg::HUE_RAMP_SPAN)) begin
			ramp_base = 16'(3 * hld_pkg::HUE_RAMP_SPAN);
		end else if (hue_cdeg >= 16'(2 * hld_pkg::HUE_RAMP_SPAN)) begin
			ramp_base = 16'(2 * hld_pkg::HUE_RAMP_SPAN);
		end else if (hue_cdeg >= hld_pkg::HUE_RAMP_SPAN) begin
			ramp_base = hld_pkg::HUE_RAMP_SPAN;
		end else begin
			ramp_base = '0;
		end
		hue_rem_full = hue_cdeg - ramp_base;
	end

	// Stage 2 onwards: ramp, weighting and channel placement.
	always_comb begin
		div6_prod   = hue_rem_s1 * hld_pkg::DIV6_MUL;
		ramp_dist   = (pos_s2 >= hld_pkg::RAMP_ONE) ? pos_s2 - hld_pkg::RAMP_ONE
		                                            : hld_pkg::RAMP_ONE - pos_s2;
		weight_full = hld_pkg::RAMP_ONE - ramp_dist;
		div125_prod = sec_prod_s4[25:3] * hld_pkg::DIV125_MUL;
		unique case (sector_s5)
			hld_pkg::SECTOR_R_G: begin
				red_d = chroma_s5; green_d = sec_s5;    blue_d = '0;
			end
			hld_pkg::SECTOR_G_R: begin
				red_d = sec_s5;    green_d = chroma_s5; blue_d = '0;
			end
			hld_pkg::SECTOR_G_B: begin
				red_d = '0;        green_d = chroma_s5; blue_d = sec_s5;
			end
			hld_pkg::SECTOR_B_G: begin
				red_d = '0;        green_d = sec_s5;    blue_d = chroma_s5;
			end
			hld_pkg::SECTOR_B_R: begin
				red_d = sec_s5;    green_d = '0;        blue_d = chroma_s5;
			end
			hld_pkg::SECTOR_R_B: begin
				red_d = chroma_s5; green_d = '0;        blue_d = sec_s5;
			end
			default: begin
				red_d = chroma_s5; green_d = '0;        blue_d = sec_s5;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (stage_en[1]) begin
			vs_prod_s1 <= value_level * saturation;
			val_s1     <= value_level;
			hue_rem_s1 <= hue_rem_full[13:0];
			sector_s1  <= sector_d;
		end
		if (stage_en[2]) begin
			chroma_s2 <= hld_pkg::div_full_scale(vs_prod_s1);
			val_s2    <= val_s1;
			pos_s2    <= div6_prod[hld_pkg::DIV6_SHIFT +: 11];
			sector_s2 <= sector_s1;
		end
		if (stage_en[3]) begin
			chroma_s3 <= chroma_s2;
			offs_s3   <= val_s2 - chroma_s2;
			weight_s3 <= weight_full[9:0];
			sector_s3 <= sector_s2;
		end
		if (stage_en[4]) begin
			chroma_s4   <= chroma_s3;
			offs_s4     <= offs_s3;
			sec_prod_s4 <= chroma_s3 * weight_s3;
			sector_s4   <= sector_s3;
		end
		if (stage_en[5]) begin
			chroma_s5 <= chroma_s4;
			offs_s5   <= offs_s4;
			sec_s5    <= div125_prod[hld_pkg::DIV125_SHIFT +: 16];
			sector_s5 <= sector_s4;
		end
		if (stage_en[6]) begin
			red_s6   <= red_d + offs_s5;
			green_s6 <= green_d + offs_s5;
			blue_s6  <= blue_d + offs_s5;
		end
	end

	assign adv = '{s7: stage_en[7], s8: stage_en[8], s9: stage_en[9], s10: stage_en[10]};

	hld_channel_scale u_red (
		.clk    (clk),
		.adv    (adv),
		.level  (red_s6),
		.period (period_q),
		.pulse  (red_pulse_us)
	);

	hld_channel_scale u_green (
		.clk    (clk),
		.adv    (adv),
		.level  (green_s6),
		.period (period_q),
		.pulse  (green_pulse_us)
	);

	hld_channel_scale u_blue (
		.clk    (clk),
		.adv    (adv),
		.level  (blue_s6),
		.period (period_q),
		.pulse  (blue_pulse_us)
	);

endmodule

[rtl/hld_channel_scale.sv]
// One colour channel of the back end: squaring, inversion for a common-anode
// LED and scaling by the PWM period, over four pipeline stages.
// Depends on hld_pkg.
module hld_channel_scale (
	input  logic              clk,
	input  hld_pkg::hld_adv_t adv,
	input  logic [15:0]       level,
	input  logic [15:0]       period,
	output logic [15:0]       pulse
);

	logic [31:0] sq_s7;
	logic [15:0] inv_s8;
	logic [31:0] prod_s9;
	logic [15:0] pulse_s10;

	always_ff @(posedge clk) begin
		if (adv.s7) begin
			sq_s7 <= level * level;
		end
		if (adv.s8) begin
			inv_s8 <= hld_pkg::FULL_SCALE - hld_pkg::div_full_scale(sq_s7);
		end
		if (adv.s9) begin
			prod_s9 <= inv_s8 * period;
		end
		if (adv.s10) begin
			pulse_s10 <= hld_pkg::div_full_scale(prod_s9);
		end
	end

	assign pulse = pulse_s10;

endmodule

[test/hsv_led_pwm_drive_tb.sv]
// Self-checking testbench for hsv_led_pwm_drive: directed colours, then random HSV
// transactions over several PWM periods, with random idling on both channels.
// Depends on hld_pkg and the hsv_led_pwm_drive RTL.
module hsv_led_pwm_drive_tb;

	typedef struct packed {
		logic [15:0] red;
		logic [15:0] green;
		logic [15:0] blue;
	} pulses_t;

	typedef struct packed {
		logic [15:0] hue;
		logic [15:0] sat;
		logic [15:0] val;
		logic        typed;
		pulses_t     want;
	} directed_row_t;

	localparam int unsigned RAMP_PERIOD = 2000;
	localparam int DIRECTED_COUNT = 20;
	localparam int PHASE_COUNT = 6;
	localparam int PHASE_ITEMS = 92;

	// Typed results assume the period of 1000 us that reset leaves behind.
	localparam directed_row_t DIRECTED_ROWS [DIRECTED_COUNT] = '{
		'{16'd0,     16'd0,     16'd0,     1'b1, '{16'd1000, 16'd1000, 16'd1000}},
		'{16'd0,     16'd65535, 16'd65535, 1'b1, '{16'd0,    16'd1000, 16'd1000}},
		'{16'd12000, 16'd65535, 16'd65535, 1'b1, '{16'd1000, 16'd0,    16'd1000}},
		'{16'd24000, 16'd65535, 16'd65535, 1'b1, '{16'd1000, 16'd1000, 16'd0}},
		'{16'd36000, 16'd65535, 16'd65535, 1'b1, '{16'd0,    16'd1000, 16'd1000}},
		'{16'd0,     16'd0,     16'd65535, 1'b1, '{16'd0,    16'd0,    16'd0}},
		'{16'd65535, 16'd65535, 16'd0,     1'b1, '{16'd1000, 16'd1000, 16'd1000}},
		'{16'd65535, 16'd65535, 16'd65535, 1'b0, '0},
		'{16'd3000,  16'd65535, 16'd65535, 1'b0, '0},
		'{16'd6000,  16'd65535, 16'd65535, 1'b0, '0},
		'{16'd9000,  16'd65535, 16'd65535, 1'b0, '0},
		'{16'd15000, 16'd65535, 16'd65535, 1'b0, '0},
		'{16'd21000, 16'd65535, 16'd65535, 1'b0, '0},
		'{16'd27000, 16'd65535, 16'd65535, 1'b0, '0},
		'{16'd33000, 16'd65535, 16'd65535, 1'b0, '0},
		'{16'd5999,  16'd65535, 16'd32768, 1'b0, '0},
		'{16'd35999, 16'd40000, 16'd65535, 1'b0, '0},
		'{16'd1,     16'd1,     16'd1,     1'b0, '0},
		'{16'hAAAA,  16'h5555,  16'hAAAA,  1'b0, '0},
		'{16'h5555,  16'hAAAA,  16'h5555,  1'b0, '0}
	};

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_wr_en = 1'b0;
	logic [15:0] cfg_wr_data = '0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [15:0] hue_cdeg = '0;
	logic [15:0] saturation = '0;
	logic [15:0] value_level = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [15:0] red_pulse_us;
	logic [15:0] green_pulse_us;
	logic [15:0] blue_pulse_us;

	pulses_t     pending_pulses [$];
	int          fail_count = 0;
	logic [15:0] period_us = hld_pkg::PWM_PERIOD_RESET;
	bit          calm = 1'b0;

	hsv_led_pwm_drive u_top (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_wr_en      (cfg_wr_en),
		.cfg_wr_data    (cfg_wr_data),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.hue_cdeg       (hue_cdeg),
		.saturation     (saturation),
		.value_level    (value_level),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.red_pulse_us   (red_pulse_us),
		.green_pulse_us (green_pulse_us),
		.blue_pulse_us  (blue_pulse_us)
	);

	function automatic logic [15:0] pulse_width(input logic [31:0] level,
			input logic [15:0] period);
		logic [31:0] squared;
		logic [31:0] inverted;
		logic [31:0] scaled;
		squared = level * level / hld_pkg::FULL_SCALE;
		inverted = hld_pkg::FULL_SCALE - squared;
		scaled = inverted * period / hld_pkg::FULL_SCALE;
		return scaled[15:0];
	endfunction

	function automatic pulses_t predict_pulses(input logic [15:0] hue, input logic [15:0] sat,
			input logic [15:0] val, input logic [15:0] period);
		logic [31:0] chroma;
		logic [31:0] pos;
		logic [31:0] ramp_dist;
		logic [31:0] second;
		logic [31:0] offset;
		logic [31:0] r;
		logic [31:0] g;
		logic [31:0] b;
		logic [2:0]  sector_idx;
		hld_pkg::hld_sector_t sector;
		pulses_t     res;
		chroma = 32'(val) * 32'(sat) / hld_pkg::FULL_SCALE;
		pos = (32'(hue) / 6) % RAMP_PERIOD;
		ramp_dist = (pos >= hld_pkg::RAMP_ONE) ? pos - hld_pkg::RAMP_ONE
			: hld_pkg::RAMP_ONE - pos;
		second = chroma * (hld_pkg::RAMP_ONE - ramp_dist) / hld_pkg::RAMP_ONE;
		offset = 32'(val) - chroma;
		sector_idx = 3'((hue % hld_pkg::HUE_WRAP) / hld_pkg::SECTOR_CDEG);
		sector = hld_pkg::hld_sector_t'(sector_idx);
		case (sector)
			hld_pkg::SECTOR_R_G: begin r = chroma; g = second; b = 0; end
			hld_pkg::SECTOR_G_R: begin r = second; g = chroma; b = 0; end
			hld_pkg::SECTOR_G_B: begin r = 0;      g = chroma; b = second; end
			hld_pkg::SECTOR_B_G: begin r = 0;      g = second; b = chroma; end
			hld_pkg::SECTOR_B_R: begin r = second; g = 0;      b = chroma; end
			default: begin r = chroma; g = 0;      b = second; end
		endcase
		res.red = pulse_width(r + offset, period);
		res.green = pulse_width(g + offset, period);
		res.blue = pulse_width(b + offset, period);
		return res;
	endfunction

	function automatic logic [15:0] pick_level();
		case ($urandom_range(0, 7))
			0: return 16'd0;
			1: return 16'hFFFF;
			2: return 16'($urandom_range(0, 255));
			3: return 16'(65535 - $urandom_range(0, 255));
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic logic [15:0] pick_hue();
		case ($urandom_range(0, 5))
			0: return 16'($urandom_range(1, 6) * 6000 - 2 + $urandom_range(0, 4));
			1: return 16'($urandom);
			2: return 16'($urandom_range(36000, 65535));
			default: return 16'($urandom_range(0, 35999));
		endcase
	endfunction

	task automatic write_period(input logic [15:0] period);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= period;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		period_us = period;
	endtask

	task automatic drive_colour(input logic [15:0] hue, input logic [15:0] sat,
			input logic [15:0] val, input logic typed, input pulses_t want);
		if (!calm && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 15)) @(posedge clk);
		end
		in_valid <= 1'b1;
		hue_cdeg <= hue;
		saturation <= sat;
		value_level <= val;
		do @(posedge clk); while (!in_ready);
		pending_pulses.push_back(typed ? want : predict_pulses(hue, sat, val, period_us));
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (pending_pulses.size() != 0) @(posedge clk);
		repeat (hld_pkg::NUM_STAGES + 2) @(posedge clk);
	endtask

	initial begin
		forever #4 clk = ~clk;
	end

	initial begin
		#4_000_000;
		$display("Test completed with failures");
		$finish;
	end

	initial begin
		forever begin
			if (!calm && $urandom_range(0, 2) == 0) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 15)) @(posedge clk);
			end
			out_ready <= 1'b1;
			repeat ($urandom_range(1, 20)) @(posedge clk);
		end
	end

	always @(posedge clk) begin
		pulses_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_pulses.size() == 0) begin
				$error("Result transaction arrived with nothing pending");
				fail_count++;
			end else begin
				want = pending_pulses.pop_front();
				if (red_pulse_us !== want.red) begin
					$error("red_pulse_us expected %0d actual %0d", want.red, red_pulse_us);
					fail_count++;
				end
				if (green_pulse_us !== want.green) begin
					$error("green_pulse_us expected %0d actual %0d", want.green,
						green_pulse_us);
					fail_count++;
				end
				if (blue_pulse_us !== want.blue) begin
					$error("blue_pulse_us expected %0d actual %0d", want.blue, blue_pulse_us);
					fail_count++;
				end
			end
		end
	end

	initial begin
		logic [15:0] period;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (DIRECTED_ROWS[i]) begin
			drive_colour(DIRECTED_ROWS[i].hue, DIRECTED_ROWS[i].sat, DIRECTED_ROWS[i].val,
				DIRECTED_ROWS[i].typed, DIRECTED_ROWS[i].want);
		end
		drain();
		for (int phase = 0; phase < PHASE_COUNT; phase++) begin
			case (phase)
				0: period = 16'hFFFF;
				1: period = 16'd1;
				2: period = 16'd0;
				5: period = 16'($urandom);
				default: period = 16'($urandom_range(1, 65535));
			endcase
			calm = (phase == PHASE_COUNT - 1);
			write_period(period);
			repeat (PHASE_ITEMS) drive_colour(pick_hue(), pick_level(), pick_level(), 1'b0, '0);
			drain();
		end
		if (fail_count == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule

[sim.f]
rtl/hld_pkg.sv
rtl/hld_channel_scale.sv
rtl/hsv_led_pwm_drive.sv
test/hsv_led_pwm_drive_tb.sv
